/* hdl/satmtv_pkg.sv */
package satmtv_pkg;

  // default widths
  localparam int COORD_BITS_DEF     = 24;
  localparam int AXIS_FRAC_BITS_DEF = 14;

  // side vectors are brought below 2^REDUCE_BITS before squaring
  localparam int REDUCE_BITS = 20;
  // root of the squared length scaled by 2^SQ_SCALE
  localparam int SQ_SCALE    = 20;
  localparam int SQ_IN_BITS  = 62;
  localparam int SQ_ROOT_BITS = 31;
  // extra numerator scale of the normalising divide (half of SQ_SCALE)
  localparam int DIV_EXTRA   = 10;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SIDE0,
    ST_SIDE1,
    ST_RED,
    ST_SQX,
    ST_SQY,
    ST_SQS,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_PX,
    ST_PY,
    ST_PACC,
    ST_OV,
    ST_SGN,
    ST_MLO,
    ST_MHI,
    ST_MSUM
  } satmtv_state_t;

endpackage

/* hdl/sat_rectangle_collision_mtv.sv */
// sequence: the four axes with their side reduction, then the projection and push steps
// throughput: one pair at a time; corners load one beat per cycle while the sequencer is
//   in its load state, and the completing beat waits while a result is held; bit-serial
//   root (31) and divider (AXIS_FRAC_BITS+31) steps
// reset: synchronous active low rst_n clears the sequencer, the loaded mask and out_valid;
//   the corner store is undefined until written
module sat_rectangle_collision_mtv
  import satmtv_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_slot,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_collide,
  output logic                         out_degenerate,
  output logic signed [COORD_BITS-1:0] out_push_x,
  output logic signed [COORD_BITS-1:0] out_push_y
);

  localparam int CB   = COORD_BITS;
  localparam int AF   = AXIS_FRAC_BITS;
  localparam int MW   = CB + 1;
  localparam int AW   = AF + 1;
  localparam int AXW  = AF + 2;
  localparam int PW   = CB + AF + 3;
  localparam int OW   = CB + 3;
  localparam int MA   = (CB + 1 > REDUCE_BITS + 1) ? CB + 1 : REDUCE_BITS + 1;
  localparam int MB   = (AF + 2 > REDUCE_BITS + 1) ? AF + 2 : REDUCE_BITS + 1;
  localparam int PRW  = MA + MB;
  localparam int NW   = REDUCE_BITS + AF + DIV_EXTRA + 1;
  localparam int CNTW = $clog2(NW);
  localparam int MFW  = CB + AF + 4;
  localparam int RB   = REDUCE_BITS;

  satmtv_state_t state_r, state_nxt;

  // corner store
  logic signed [CB-1:0] cx_r [8];
  logic signed [CB-1:0] cy_r [8];
  logic [7:0]           mask_r, mask_nxt;

  logic signed [CB-1:0] v0x_r, v0x_nxt, v0y_r, v0y_nxt;
  logic [MW-1:0]        mx_r, mx_nxt, my_r, my_nxt;
  logic                 sx_r, sx_nxt, sy_r, sy_nxt;

  logic signed [PRW-1:0] prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;

  logic [SQ_IN_BITS-1:0]   sq_n_r, sq_n_nxt;
  logic [SQ_ROOT_BITS+1:0] sq_rem_r, sq_rem_nxt;
  logic [SQ_ROOT_BITS-1:0] root_r, root_nxt;

  logic [NW-1:0]         dn_r, dn_nxt;
  logic [SQ_ROOT_BITS:0] dr_r, dr_nxt;
  logic [AW-1:0]         q_r, q_nxt;
  logic                  div_sel_r, div_sel_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;

  logic signed [AXW-1:0] ax_r [4];
  logic signed [AXW-1:0] ay_r [4];
  logic signed [AXW-1:0] ax_nxt [4];
  logic signed [AXW-1:0] ay_nxt [4];

  logic [1:0] k_r, k_nxt, bi_r, bi_nxt;
  logic [2:0] j_r, j_nxt;
  logic       comp_r, comp_nxt;

  logic signed [PW-1:0] alo_r, alo_nxt, ahi_r, ahi_nxt, blo_r, blo_nxt, bhi_r, bhi_nxt;
  logic signed [PW-1:0] best_r, best_nxt;
  logic signed [PW-1:0] balo_r, balo_nxt, bahi_r, bahi_nxt, bblo_r, bblo_nxt;
  logic signed [PW-1:0] bbhi_r, bbhi_nxt;
  logic [OW-1:0]        o_r, o_nxt;
  logic                 neg_r, neg_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_collide_r, out_collide_nxt;
  logic                 out_degenerate_r, out_degenerate_nxt;
  logic signed [CB-1:0] out_push_x_r, out_push_x_nxt, out_push_y_r, out_push_y_nxt;

  // shared helpers
  logic                 accept_in, mask_full, side_zero, red_more, cnt_zero, ov_pos;
  logic [7:0]           mask_or;
  logic [2:0]           rd_idx;
  logic signed [CB-1:0] rd_x, rd_y;
  logic signed [CB:0]   dx, dy;
  logic [MW-1:0]        dx_mag, dy_mag;
  logic [RB-1:0]        mx_red, my_red;
  logic signed [PRW:0]  sum_w;
  logic signed [PW-1:0] p_val, hmin, lmax, ov, t_hi, t_lo, bahi_sh, balo_sh;
  logic [PW-1:0]        o_sum;
  logic [SQ_ROOT_BITS+3:0] sq_t, sq_trial;
  logic                 sq_ge;
  logic [SQ_ROOT_BITS+1:0] dv_t;
  logic                 dv_ge;
  logic [AW-1:0]        q_fin;
  logic signed [AXW-1:0] a_sel, a_abs;
  logic                 a_neg, flip;
  logic [AW-1:0]        a_mag;
  logic [MFW-1:0]       mfull, mr, mc, lim;
  logic signed [CB-1:0] push_v;

  // handshake
  assign mask_or   = mask_r | (8'd1 << in_slot);
  assign mask_full = (mask_or == 8'hFF);
  assign in_stall  = (state_r != ST_LOAD) || (out_valid_r && mask_full);
  assign accept_in = in_valid && !in_stall;

  // corner read port
  always_comb begin
    case (state_r)
      ST_SIDE0: rd_idx = {k_r[1], 2'b00};
      ST_SIDE1: rd_idx = {k_r[1], k_r[0], 1'b1};
      default:  rd_idx = j_r;
    endcase
  end
  assign rd_x = cx_r[rd_idx];
  assign rd_y = cy_r[rd_idx];

  // side vector and its magnitudes
  assign dx        = (CB+1)'(v0x_r) - (CB+1)'(rd_x);
  assign dy        = (CB+1)'(v0y_r) - (CB+1)'(rd_y);
  assign dx_mag    = MW'(dx[CB] ? -dx : dx);
  assign dy_mag    = MW'(dy[CB] ? -dy : dy);
  assign side_zero = (dx_mag == '0) && (dy_mag == '0);
  assign red_more  = ((mx_r >> RB) != '0) || ((my_r >> RB) != '0);
  assign mx_red    = RB'(mx_r);
  assign my_red    = RB'(my_r);
  assign cnt_zero  = (cnt_r == '0);

  // root step
  assign sq_t     = {sq_rem_r, sq_n_r[SQ_IN_BITS-1 -: 2]};
  assign sq_trial = (SQ_ROOT_BITS+4)'({root_r, 2'b01});
  assign sq_ge    = (sq_t >= sq_trial);

  // divide step
  assign dv_t  = {dr_r, dn_r[NW-1]};
  assign dv_ge = (dv_t >= (SQ_ROOT_BITS+2)'(root_r));
  assign q_fin = {q_r[AW-2:0], dv_ge};

  // projection sum and interval overlap
  assign sum_w   = acc_r + prod_r;
  assign p_val   = PW'(sum_w);
  assign hmin    = (ahi_r < bhi_r) ? ahi_r : bhi_r;
  assign lmax    = (alo_r > blo_r) ? alo_r : blo_r;
  assign ov      = hmin - lmax;
  assign ov_pos  = (ov > 0);
  assign bahi_sh = bahi_r + best_r;
  assign balo_sh = balo_r + best_r;
  assign t_hi    = (bahi_sh < bbhi_r) ? bahi_sh : bbhi_r;
  assign t_lo    = (balo_sh > bblo_r) ? balo_sh : bblo_r;
  assign o_sum   = $unsigned(best_r) + (PW'(1) << (AF - 1));

  // push component
  assign a_sel  = comp_r ? ay_r[bi_r] : ax_r[bi_r];
  assign a_neg  = a_sel[AXW-1];
  assign a_abs  = a_neg ? -a_sel : a_sel;
  assign a_mag  = AW'(a_abs);
  assign flip   = a_neg ^ neg_r;
  assign mfull  = MFW'($unsigned(acc_r)) + (MFW'($unsigned(prod_r)) << CB);
  assign mr     = (mfull + (MFW'(1) << (AF - 1))) >> AF;
  assign lim    = MFW'(1) << (CB - 1);
  assign mc     = (mr > lim) ? lim : mr;
  assign push_v = flip ? CB'(MFW'(0) - mc)
                       : ((mc == lim) ? {1'b0, {(CB-1){1'b1}}} : CB'(mc));

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQX: begin
        mul_a = MA'({1'b0, mx_red});
        mul_b = MB'({1'b0, mx_red});
      end
      ST_SQY: begin
        mul_a = MA'({1'b0, my_red});
        mul_b = MB'({1'b0, my_red});
      end
      ST_PX: begin
        mul_a = MA'(rd_x);
        mul_b = MB'(ax_r[k_r]);
      end
      ST_PY: begin
        mul_a = MA'(rd_y);
        mul_b = MB'(ay_r[k_r]);
      end
      ST_MLO: begin
        mul_a = MA'({1'b0, o_r[CB-1:0]});
        mul_b = MB'({1'b0, a_mag});
      end
      ST_MHI: begin
        mul_a = MA'({1'b0, o_r[OW-1:CB]});
        mul_b = MB'({1'b0, a_mag});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (accept_in && mask_full) state_nxt = ST_SIDE0;
      ST_SIDE0: state_nxt = ST_SIDE1;
      ST_SIDE1: state_nxt = side_zero ? ST_LOAD : ST_RED;
      ST_RED:   if (!red_more) state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SQS;
      ST_SQS:   state_nxt = ST_SQRT;
      ST_SQRT:  if (cnt_zero) state_nxt = ST_DIVI;
      ST_DIVI:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_zero) begin
          if (!div_sel_r)      state_nxt = ST_DIVI;
          else if (k_r == 2'd3) state_nxt = ST_PX;
          else                 state_nxt = ST_SIDE0;
        end
      end
      ST_PX:    state_nxt = ST_PY;
      ST_PY:    state_nxt = ST_PACC;
      ST_PACC:  state_nxt = (j_r == 3'd7) ? ST_OV : ST_PX;
      ST_OV: begin
        if (!ov_pos)          state_nxt = ST_LOAD;
        else if (k_r == 2'd3) state_nxt = ST_SGN;
        else                  state_nxt = ST_PX;
      end
      ST_SGN:   state_nxt = ST_MLO;
      ST_MLO:   state_nxt = ST_MHI;
      ST_MHI:   state_nxt = ST_MSUM;
      ST_MSUM:  state_nxt = comp_r ? ST_LOAD : ST_MLO;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // datapath next values
  always_comb begin
    mask_nxt           = mask_r;
    v0x_nxt            = v0x_r;
    v0y_nxt            = v0y_r;
    mx_nxt             = mx_r;
    my_nxt             = my_r;
    sx_nxt             = sx_r;
    sy_nxt             = sy_r;
    prod_nxt           = mul_a * mul_b;
    acc_nxt            = acc_r;
    sq_n_nxt           = sq_n_r;
    sq_rem_nxt         = sq_rem_r;
    root_nxt           = root_r;
    dn_nxt             = dn_r;
    dr_nxt             = dr_r;
    q_nxt              = q_r;
    div_sel_nxt        = div_sel_r;
    cnt_nxt            = cnt_r;
    ax_nxt             = ax_r;
    ay_nxt             = ay_r;
    k_nxt              = k_r;
    j_nxt              = j_r;
    bi_nxt             = bi_r;
    comp_nxt           = comp_r;
    alo_nxt            = alo_r;
    ahi_nxt            = ahi_r;
    blo_nxt            = blo_r;
    bhi_nxt            = bhi_r;
    best_nxt           = best_r;
    balo_nxt           = balo_r;
    bahi_nxt           = bahi_r;
    bblo_nxt           = bblo_r;
    bbhi_nxt           = bbhi_r;
    o_nxt              = o_r;
    neg_nxt            = neg_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_collide_nxt    = out_collide_r;
    out_degenerate_nxt = out_degenerate_r;
    out_push_x_nxt     = out_push_x_r;
    out_push_y_nxt     = out_push_y_r;
    case (state_r)
      // corner beats
      ST_LOAD: begin
        if (accept_in) begin
          mask_nxt = mask_full ? 8'h00 : mask_or;
          if (mask_full) begin
            k_nxt       = 2'd0;
            div_sel_nxt = 1'b0;
          end
        end
      end
      ST_SIDE0: begin
        v0x_nxt = rd_x;
        v0y_nxt = rd_y;
      end
      // side vector, zero length ends the pair as degenerate
      ST_SIDE1: begin
        mx_nxt = dx_mag;
        my_nxt = dy_mag;
        sx_nxt = dx[CB];
        sy_nxt = dy[CB];
        if (side_zero) begin
          out_valid_nxt      = 1'b1;
          out_collide_nxt    = 1'b0;
          out_degenerate_nxt = 1'b1;
          out_push_x_nxt     = '0;
          out_push_y_nxt     = '0;
        end
      end
      ST_RED: begin
        if (red_more) begin
          mx_nxt = mx_r >> 1;
          my_nxt = my_r >> 1;
        end
      end
      ST_SQY: acc_nxt = prod_r;
      // squared length into the root unit
      ST_SQS: begin
        sq_n_nxt   = SQ_IN_BITS'(sum_w) << SQ_SCALE;
        sq_rem_nxt = '0;
        root_nxt   = '0;
        cnt_nxt    = CNTW'(SQ_ROOT_BITS - 1);
      end
      // one root bit per cycle
      ST_SQRT: begin
        sq_n_nxt   = sq_n_r << 2;
        sq_rem_nxt = (SQ_ROOT_BITS+2)'(sq_ge ? sq_t - sq_trial : sq_t);
        root_nxt   = {root_r[SQ_ROOT_BITS-2:0], sq_ge};
        cnt_nxt    = cnt_r - 1'b1;
      end
      ST_DIVI: begin
        dn_nxt  = (NW'(div_sel_r ? mx_red : my_red) << (AF + DIV_EXTRA))
                + NW'(root_r >> 1);
        dr_nxt  = '0;
        q_nxt   = '0;
        cnt_nxt = CNTW'(NW - 1);
      end
      // one quotient bit per cycle
      ST_DIV: begin
        dn_nxt  = dn_r << 1;
        dr_nxt  = (SQ_ROOT_BITS+1)'(dv_ge ? dv_t - (SQ_ROOT_BITS+2)'(root_r) : dv_t);
        q_nxt   = q_fin;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_zero) begin
          if (!div_sel_r) begin
            ax_nxt[k_r] = sy_r ? $signed({1'b0, q_fin}) : -$signed({1'b0, q_fin});
            div_sel_nxt = 1'b1;
          end else begin
            ay_nxt[k_r] = sx_r ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
            div_sel_nxt = 1'b0;
            k_nxt       = k_r + 1'b1;
            j_nxt       = 3'd0;
          end
        end
      end
      ST_PY: acc_nxt = prod_r;
      // running interval per body
      ST_PACC: begin
        if (!j_r[2]) begin
          if (j_r[1:0] == 2'd0 || p_val < alo_r) alo_nxt = p_val;
          if (j_r[1:0] == 2'd0 || p_val > ahi_r) ahi_nxt = p_val;
        end else begin
          if (j_r[1:0] == 2'd0 || p_val < blo_r) blo_nxt = p_val;
          if (j_r[1:0] == 2'd0 || p_val > bhi_r) bhi_nxt = p_val;
        end
        j_nxt = j_r + 1'b1;
      end
      // overlap on this axis: none ends the pair without collision, else keep the first smallest
      ST_OV: begin
        if (!ov_pos) begin
          out_valid_nxt      = 1'b1;
          out_collide_nxt    = 1'b0;
          out_degenerate_nxt = 1'b0;
          out_push_x_nxt     = '0;
          out_push_y_nxt     = '0;
        end else if (k_r == 2'd0 || ov < best_r) begin
          best_nxt = ov;
          bi_nxt   = k_r;
          balo_nxt = alo_r;
          bahi_nxt = ahi_r;
          bblo_nxt = blo_r;
          bbhi_nxt = bhi_r;
        end
        k_nxt = k_r + 1'b1;
      end
      // direction test and rounded overlap
      ST_SGN: begin
        neg_nxt  = (t_hi > t_lo);
        o_nxt    = OW'(o_sum >> AF);
        comp_nxt = 1'b0;
      end
      ST_MHI: acc_nxt = prod_r;
      ST_MSUM: begin
        if (!comp_r) begin
          out_push_x_nxt = push_v;
          comp_nxt       = 1'b1;
        end else begin
          out_push_y_nxt     = push_v;
          out_valid_nxt      = 1'b1;
          out_collide_nxt    = 1'b1;
          out_degenerate_nxt = 1'b0;
          comp_nxt           = 1'b0;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // corner store writes
  always_ff @(posedge clk) begin
    if (accept_in) begin
      cx_r[in_slot] <= in_vertex_x;
      cy_r[in_slot] <= in_vertex_y;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      comp_r      <= 1'b0;
      div_sel_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      comp_r      <= comp_nxt;
      div_sel_r   <= div_sel_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    v0x_r            <= v0x_nxt;
    v0y_r            <= v0y_nxt;
    mx_r             <= mx_nxt;
    my_r             <= my_nxt;
    sx_r             <= sx_nxt;
    sy_r             <= sy_nxt;
    prod_r           <= prod_nxt;
    acc_r            <= acc_nxt;
    sq_n_r           <= sq_n_nxt;
    sq_rem_r         <= sq_rem_nxt;
    root_r           <= root_nxt;
    dn_r             <= dn_nxt;
    dr_r             <= dr_nxt;
    q_r              <= q_nxt;
    ax_r             <= ax_nxt;
    ay_r             <= ay_nxt;
    bi_r             <= bi_nxt;
    alo_r            <= alo_nxt;
    ahi_r            <= ahi_nxt;
    blo_r            <= blo_nxt;
    bhi_r            <= bhi_nxt;
    best_r           <= best_nxt;
    balo_r           <= balo_nxt;
    bahi_r           <= bahi_nxt;
    bblo_r           <= bblo_nxt;
    bbhi_r           <= bbhi_nxt;
    o_r              <= o_nxt;
    neg_r            <= neg_nxt;
    out_collide_r    <= out_collide_nxt;
    out_degenerate_r <= out_degenerate_nxt;
    out_push_x_r     <= out_push_x_nxt;
    out_push_y_r     <= out_push_y_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_collide    = out_collide_r;
  assign out_degenerate = out_degenerate_r;
  assign out_push_x     = out_push_x_r;
  assign out_push_y     = out_push_y_r;

`ifndef SYNTH
  // degenerate pair never reports a collision
  a_deg_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_collide)
    else $error("degenerate result with collide set");

  // a result without collision carries no push
  a_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_collide |-> (out_push_x == '0) && (out_push_y == '0))
    else $error("push on a non-colliding result");

  // the completing corner beat starts evaluation with an empty mask
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in && mask_full |=> (state_r == ST_SIDE0) && (mask_r == '0))
    else $error("pair evaluation did not start");

  // a result appears only at the end of an evaluation
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) != ST_LOAD)
    else $error("result raised while loading");
`endif

endmodule

/* test/sat_rectangle_collision_mtv_tb.sv */
module sat_rectangle_collision_mtv_tb
  import satmtv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int AF = AXIS_FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 800;

  typedef struct packed {
    logic          collide;
    logic          degenerate;
    logic [CB-1:0] push_x;
    logic [CB-1:0] push_y;
  } mtv_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_slot = '0;
  logic signed [CB-1:0] in_vertex_x = '0;
  logic signed [CB-1:0] in_vertex_y = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_collide;
  logic out_degenerate;
  logic signed [CB-1:0] out_push_x;
  logic signed [CB-1:0] out_push_y;

  bit idle_on = 1'b1;
  int quiet_cycles = 0;

  sat_rectangle_collision_mtv dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // collision predictor and store of pending results
  class mtv_scoreboard;
    longint corner_x[8];
    longint corner_y[8];
    logic [7:0] loaded;
    mtv_t pending_mtv[$];
    int errors;

    function new();
      loaded = '0;
      errors = 0;
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // unit normal of one side, 0 when the side has zero length
    function automatic bit side_normal(longint dx, longint dy, output longint ax,
                                       output longint ay);
      longint unsigned mx, my, s, r, nx, ny;
      mx = mag(dx);
      my = mag(dy);
      ax = 0;
      ay = 0;
      if (mx == 0 && my == 0) return 1'b0;
      while (mx >= (64'd1 << REDUCE_BITS) || my >= (64'd1 << REDUCE_BITS)) begin
        mx >>= 1;
        my >>= 1;
      end
      s = mx * mx + my * my;
      r = int_root(s << SQ_SCALE);
      ny = ((my << (AF + DIV_EXTRA)) + (r >> 1)) / r;
      nx = ((mx << (AF + DIV_EXTRA)) + (r >> 1)) / r;
      ax = dy < 0 ? longint'(ny) : -longint'(ny);
      ay = dx < 0 ? -longint'(nx) : longint'(nx);
      return 1'b1;
    endfunction

    function automatic void span(int base, longint ax, longint ay, output longint lo,
                                 output longint hi);
      longint p;
      lo = 0;
      hi = 0;
      for (int k = 0; k < 4; k++) begin
        p = corner_x[base+k] * ax + corner_y[base+k] * ay;
        if (k == 0 || p < lo) lo = p;
        if (k == 0 || p > hi) hi = p;
      end
    endfunction

    function automatic longint overlap(longint alo, longint ahi, longint blo, longint bhi);
      longint d;
      d = (ahi < bhi ? ahi : bhi) - (alo > blo ? alo : blo);
      return d > 0 ? d : 0;
    endfunction

    function automatic logic [CB-1:0] push_part(longint unsigned o, longint a, bit neg);
      longint unsigned m;
      longint lim, v;
      lim = longint'(1) << (CB - 1);
      m = (o * mag(a) + (64'd1 << (AF - 1))) >> AF;
      if (m > lim) m = lim;
      v = m;
      if ((a < 0) != neg) v = -v;
      if (v > lim - 1) v = lim - 1;
      return v[CB-1:0];
    endfunction

    // accepted corner beat
    function void note_corner(logic [2:0] slot, logic signed [CB-1:0] x,
                              logic signed [CB-1:0] y);
      longint axx[4], axy[4];
      longint best, balo, bahi, bblo, bbhi, alo, ahi, blo, bhi, ov;
      longint unsigned o;
      int bi;
      bit ok, neg;
      mtv_t r;
      corner_x[slot] = x;
      corner_y[slot] = y;
      loaded[slot] = 1'b1;
      if (loaded != 8'hff) return;
      loaded = '0;
      r = '0;
      ok = 1'b1;
      best = 0; balo = 0; bahi = 0; bblo = 0; bbhi = 0; bi = 0;
      for (int i = 0; i < 2; i++) begin
        ok = side_normal(corner_x[i*4] - corner_x[i*4+1], corner_y[i*4] - corner_y[i*4+1],
                         axx[i*2], axy[i*2]) && ok;
        ok = side_normal(corner_x[i*4] - corner_x[i*4+3], corner_y[i*4] - corner_y[i*4+3],
                         axx[i*2+1], axy[i*2+1]) && ok;
      end
      if (!ok) begin
        r.degenerate = 1'b1;
        pending_mtv.insert(pending_mtv.size(), r);
        return;
      end
      for (int i = 0; i < 4; i++) begin
        span(0, axx[i], axy[i], alo, ahi);
        span(4, axx[i], axy[i], blo, bhi);
        ov = overlap(alo, ahi, blo, bhi);
        if (ov == 0) begin
          pending_mtv.insert(pending_mtv.size(), r);
          return;
        end
        if (i == 0 || ov < best) begin
          best = ov; bi = i; balo = alo; bahi = ahi; bblo = blo; bbhi = bhi;
        end
      end
      neg = overlap(balo + best, bahi + best, bblo, bbhi) != 0;
      o = (longint'(best) + (longint'(1) << (AF - 1))) >> AF;
      r.collide = 1'b1;
      r.push_x = push_part(o, axx[bi], neg);
      r.push_y = push_part(o, axy[bi], neg);
      pending_mtv.insert(pending_mtv.size(), r);
    endfunction

    task report(string what, logic [CB-1:0] got, logic [CB-1:0] want);
      errors++;
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // accepted result beat
    task check_result(mtv_t got);
      mtv_t want;
      if (pending_mtv.size() == 0) begin
        report("unexpected result beat", '0, '0);
        return;
      end
      want = pending_mtv.pop_front();
      if (got.collide !== want.collide)
        report("collide", CB'(got.collide), CB'(want.collide));
      if (got.degenerate !== want.degenerate)
        report("degenerate", CB'(got.degenerate), CB'(want.degenerate));
      if (got.push_x !== want.push_x) report("push_x", got.push_x, want.push_x);
      if (got.push_y !== want.push_y) report("push_y", got.push_y, want.push_y);
    endtask
  endclass

  mtv_scoreboard sb = new();

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall)
        sb.check_result({out_collide, out_degenerate, out_push_x, out_push_y});
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver back-pressure
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(40, 80)) @(posedge clk);
      end
    end
  end

  // one corner beat
  task send_corner(logic [2:0] slot, logic signed [CB-1:0] x, logic signed [CB-1:0] y);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_slot <= slot;
    in_vertex_x <= x;
    in_vertex_y <= y;
    do @(posedge clk); while (in_stall);
    sb.note_corner(slot, x, y);
  endtask

  // rectangle pair built from a direction, extents and centres
  task send_pair(longint cx[2], longint cy[2], longint ux[2], longint uy[2],
                 longint ha[2], longint hb[2], bit shuffle, bit rewrite);
    longint px[8], py[8];
    int order[8];
    int t, j;
    for (int b = 0; b < 2; b++) begin
      px[b*4]   = cx[b] + ha[b]*ux[b] - hb[b]*uy[b];
      py[b*4]   = cy[b] + ha[b]*uy[b] + hb[b]*ux[b];
      px[b*4+1] = cx[b] - ha[b]*ux[b] - hb[b]*uy[b];
      py[b*4+1] = cy[b] - ha[b]*uy[b] + hb[b]*ux[b];
      px[b*4+2] = cx[b] - ha[b]*ux[b] + hb[b]*uy[b];
      py[b*4+2] = cy[b] - ha[b]*uy[b] - hb[b]*ux[b];
      px[b*4+3] = cx[b] + ha[b]*ux[b] + hb[b]*uy[b];
      py[b*4+3] = cy[b] + ha[b]*uy[b] - hb[b]*ux[b];
    end
    for (int i = 0; i < 8; i++) order[i] = i;
    if (shuffle) begin
      for (int i = 7; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (rewrite && i < 7 && $urandom_range(0, 3) == 0)
        send_corner(3'(order[i]), CB'($urandom), CB'($urandom));
      send_corner(3'(order[i]), CB'(px[order[i]]), CB'(py[order[i]]));
    end
  endtask

  // random pair, mostly small, a few large enough to need side reduction
  task random_pair();
    longint cx[2], cy[2], ux[2], uy[2], ha[2], hb[2];
    bit big;
    big = $urandom_range(0, 9) == 0;
    for (int b = 0; b < 2; b++) begin
      do begin
        ux[b] = big ? $signed($urandom_range(0, 2048)) - 1024 : $signed($urandom_range(0, 128)) - 64;
        uy[b] = big ? $signed($urandom_range(0, 2048)) - 1024 : $signed($urandom_range(0, 128)) - 64;
      end while (ux[b] == 0 && uy[b] == 0);
      ha[b] = $urandom_range(big ? 1 : 0, big ? 2047 : 200);
      hb[b] = $urandom_range(1, big ? 2047 : 200);
      if ($urandom_range(0, 29) == 0) hb[b] = 0;
    end
    cx[0] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    cy[0] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    cx[1] = cx[0] + $signed($urandom_range(0, big ? 1 << 21 : 40000)) - (big ? 1 << 20 : 20000);
    cy[1] = cy[0] + $signed($urandom_range(0, big ? 1 << 21 : 40000)) - (big ? 1 << 20 : 20000);
    send_pair(cx, cy, ux, uy, ha, hb, $urandom_range(0, 2) == 0, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    longint cx[2], cy[2], ux[2], uy[2], ha[2], hb[2];
    int count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // degenerate: every corner at the top extreme
    for (int i = 0; i < 8; i++) send_corner(3'(i), 24'sh7fffff, 24'sh7fffff);
    // full-range first body around a small second one, reduction and saturation
    send_corner(3'd0, 24'sh7fffff, 24'sh7fffff);
    send_corner(3'd1, 24'sh800000, 24'sh7fffff);
    send_corner(3'd2, 24'sh800000, 24'sh800000);
    send_corner(3'd3, 24'sh7fffff, 24'sh800000);
    send_corner(3'd4, CB'(100), CB'(100));
    send_corner(3'd5, CB'(-100), CB'(100));
    send_corner(3'd6, CB'(-100), CB'(-100));
    // rewritten slot before the set completes
    send_corner(3'd6, CB'(-200), CB'(-200));
    send_corner(3'd7, CB'(100), CB'(-100));
    // disjoint pair, no collision
    cx = '{0, 50000}; cy = '{0, 0}; ux = '{1, 0}; uy = '{0, 1};
    ha = '{256, 256}; hb = '{256, 256};
    send_pair(cx, cy, ux, uy, ha, hb, 1'b0, 1'b0);
    // barely touching pair: tiny translation
    cx = '{0, 511}; cy = '{0, 7};
    send_pair(cx, cy, ux, uy, ha, hb, 1'b1, 1'b0);

    // random pairs with a share of noise beats
    count = 0;
    while (count < 600) begin
      idle_on = $urandom_range(0, 3) != 0;
      if (count > 300 && count < 320) begin
        // sender holds off until every result is in
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_mtv.size() != 0);
        count = 320;
      end
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_corner(3'($urandom_range(0, 7)), CB'($urandom), CB'($urandom));
          count++;
        end
      end else begin
        random_pair();
        count += 8;
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (sb.pending_mtv.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_mtv.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
